// ===== rtl/lfdc_pkg.sv =====
package lfdc_pkg;

	typedef logic [2:0]  level_t;
	typedef logic [6:0]  ratio_t;
	typedef logic [13:0] duty_t;

	typedef enum logic [1:0] {
		RegLineThreshold = 2'd0,
		RegStopEchoTicks = 2'd1,
		RegAutoSpeed     = 2'd2,
		RegBlinkPeriodMs = 2'd3
	} reg_index_t;

	localparam int unsigned CfgDataWidth = 16;

	localparam level_t LevelMin = 3'd0;
	localparam level_t LevelMid = 3'd3;
	localparam level_t LevelMax = 3'd6;

	localparam duty_t  FullDuty   = 14'd10000;
	localparam ratio_t RatioFull  = 7'd100;
	localparam ratio_t RatioZero  = 7'd0;

	localparam logic [7:0] KeyMode   = 8'h37;
	localparam logic [7:0] KeyFaster = 8'h38;
	localparam logic [7:0] KeySlower = 8'h32;
	localparam logic [7:0] KeyRight  = 8'h36;
	localparam logic [7:0] KeyLeft   = 8'h34;
	localparam logic [7:0] KeyCenter = 8'h35;

	function automatic ratio_t speed_mag_of(input level_t level);
		ratio_t mag;
		unique case (level)
			3'd0:    mag = 7'd90;
			3'd1:    mag = 7'd65;
			3'd2:    mag = 7'd40;
			3'd3:    mag = 7'd0;
			3'd4:    mag = 7'd40;
			3'd5:    mag = 7'd65;
			default: mag = 7'd90;
		endcase
		return mag;
	endfunction

	function automatic ratio_t left_ratio_of(input level_t level);
		ratio_t r;
		unique case (level)
			3'd0:    r = 7'd50;
			3'd1:    r = 7'd65;
			3'd2:    r = 7'd80;
			default: r = 7'd100;
		endcase
		return r;
	endfunction

	function automatic ratio_t right_ratio_of(input level_t level);
		ratio_t r;
		unique case (level)
			3'd4:    r = 7'd80;
			3'd5:    r = 7'd65;
			3'd6:    r = 7'd50;
			default: r = 7'd100;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/lfdc_duty.sv =====
module lfdc_duty (
	input  logic            forward,
	input  lfdc_pkg::ratio_t speed_mag,
	input  lfdc_pkg::ratio_t ratio,
	output lfdc_pkg::duty_t  duty
);
	import lfdc_pkg::*;

	duty_t mag;

	assign mag = {7'b0, speed_mag} * {7'b0, ratio};

	always_comb begin
		if (forward) begin
			duty = (mag >= FullDuty) ? '0 : duty_t'(FullDuty - mag);
		end else begin
			duty = (mag > FullDuty) ? FullDuty : mag;
		end
	end

endmodule

// ===== rtl/line_follower_drive_controller_core.sv =====
// Drive controller for a line following car, one control tick per input beat.
// The input channel (in_valid/in_ready) carries the received key, both line
// sensor samples, the echo width and the millisecond flag of one tick. The
// output channel (out_valid/out_ready) returns one beat per input beat with
// the motor direction, both inverted PWM duties, the LED level and the mode.
// An input beat is held in an input register, the mode, levels, ratios and
// LED are updated from it combinationally, and the result lands in an output
// register. One beat per cycle is sustained while out_ready stays high; the
// only loop is the state update between the input and output registers.
// When the receiver stalls, the output register holds its beat and the input
// register still takes one more beat; after that in_ready drops until the
// output drains. The configuration port writes a register on any cycle with
// cfg_we high and is meant to be used only while the block is idle.
// Reset sets manual mode, both levels to the middle, ratios to zero, the LED
// off, the blink counter to zero, and the registers to their defaults.
module line_follower_drive_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  lfdc_pkg::reg_index_t              cfg_index,
	input  logic [lfdc_pkg::CfgDataWidth-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        command,
	input  logic [11:0]                       right_sensor,
	input  logic [11:0]                       left_sensor,
	input  logic [15:0]                       echo_ticks,
	input  logic                              ms_elapsed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              forward,
	output lfdc_pkg::duty_t                   left_duty,
	output lfdc_pkg::duty_t                   right_duty,
	output logic                              led_on,
	output logic                              auto_active
);
	import lfdc_pkg::*;

	logic [11:0] line_threshold_q;
	logic [15:0] stop_echo_ticks_q;
	ratio_t      auto_speed_q;
	logic [15:0] blink_period_ms_q;

	logic        auto_mode_q;
	level_t      speed_level_q;
	level_t      steer_level_q;
	ratio_t      left_ratio_q;
	ratio_t      right_ratio_q;
	logic [15:0] blink_count_q;
	logic        led_level_q;

	logic        valid_s1;
	logic [7:0]  command_s1;
	logic [11:0] right_sensor_s1;
	logic [11:0] left_sensor_s1;
	logic [15:0] echo_ticks_s1;
	logic        ms_elapsed_s1;

	logic        out_valid_q;
	logic        forward_q;
	duty_t       left_duty_q;
	duty_t       right_duty_q;
	logic        led_on_q;
	logic        auto_active_q;

	logic        adv;
	logic        auto_n;
	level_t      speed_n;
	level_t      steer_n;
	ratio_t      left_ratio_n;
	ratio_t      right_ratio_n;
	logic [15:0] blink_inc;
	logic [15:0] blink_n;
	logic        led_n;
	logic        fwd_n;
	ratio_t      mag_n;
	logic        stop;
	logic        r_on;
	logic        l_on;
	duty_t       left_duty_n;
	duty_t       right_duty_n;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign stop = echo_ticks_s1 < stop_echo_ticks_q;
	assign r_on = right_sensor_s1 > line_threshold_q;
	assign l_on = left_sensor_s1 > line_threshold_q;

	always_comb begin
		auto_n        = auto_mode_q;
		speed_n       = speed_level_q;
		steer_n       = steer_level_q;
		left_ratio_n  = left_ratio_q;
		right_ratio_n = right_ratio_q;
		fwd_n         = 1'b1;
		mag_n         = '0;

		if (command_s1 == KeyMode) begin
			auto_n = !auto_mode_q;
			if (!auto_mode_q) begin
				speed_n = LevelMid;
				steer_n = LevelMid;
			end
		end

		if (!auto_n) begin
			unique case (command_s1)
				KeyFaster: if (speed_level_q < LevelMax) speed_n = speed_level_q + 3'd1;
				KeySlower: if (speed_level_q > LevelMin) speed_n = speed_level_q - 3'd1;
				KeyRight:  if (steer_level_q < LevelMax) steer_n = steer_level_q + 3'd1;
				KeyLeft:   if (steer_level_q > LevelMin) steer_n = steer_level_q - 3'd1;
				KeyCenter: begin
					speed_n = LevelMid;
					steer_n = LevelMid;
				end
				default: ;
			endcase
			mag_n         = speed_mag_of(speed_n);
			fwd_n         = speed_n >= LevelMid;
			left_ratio_n  = left_ratio_of(steer_n);
			right_ratio_n = right_ratio_of(steer_n);
		end else if (stop) begin
			mag_n = '0;
		end else begin
			mag_n = auto_speed_q;
			if (r_on == l_on) begin
				left_ratio_n  = RatioFull;
				right_ratio_n = RatioFull;
			end else if (r_on) begin
				left_ratio_n  = RatioZero;
				right_ratio_n = RatioFull;
			end else begin
				left_ratio_n  = RatioFull;
				right_ratio_n = RatioZero;
			end
		end
	end

	always_comb begin
		blink_inc = (ms_elapsed_s1 && blink_count_q != 16'hFFFF) ?
			blink_count_q + 16'd1 : blink_count_q;
		blink_n = blink_inc;
		led_n   = led_level_q;
		if (!auto_n) begin
			led_n = 1'b1;
		end else if (blink_inc >= blink_period_ms_q) begin
			blink_n = '0;
			led_n   = !led_level_q;
		end
	end

	lfdc_duty u_left_duty (
		.forward   (fwd_n),
		.speed_mag (mag_n),
		.ratio     (left_ratio_n),
		.duty      (left_duty_n)
	);

	lfdc_duty u_right_duty (
		.forward   (fwd_n),
		.speed_mag (mag_n),
		.ratio     (right_ratio_n),
		.duty      (right_duty_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_threshold_q  <= 12'd2000;
			stop_echo_ticks_q <= 16'd30;
			auto_speed_q      <= 7'd90;
			blink_period_ms_q <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegLineThreshold: line_threshold_q  <= cfg_data[11:0];
				RegStopEchoTicks: stop_echo_ticks_q <= cfg_data;
				RegAutoSpeed:     auto_speed_q      <= cfg_data[6:0];
				RegBlinkPeriodMs: blink_period_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1      <= command;
			right_sensor_s1 <= right_sensor;
			left_sensor_s1  <= left_sensor;
			echo_ticks_s1   <= echo_ticks;
			ms_elapsed_s1   <= ms_elapsed;
		end
		if (adv) begin
			forward_q     <= fwd_n;
			left_duty_q   <= left_duty_n;
			right_duty_q  <= right_duty_n;
			led_on_q      <= led_n;
			auto_active_q <= auto_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			auto_mode_q   <= 1'b0;
			speed_level_q <= LevelMid;
			steer_level_q <= LevelMid;
			left_ratio_q  <= '0;
			right_ratio_q <= '0;
			blink_count_q <= '0;
			led_level_q   <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				auto_mode_q   <= auto_n;
				speed_level_q <= speed_n;
				steer_level_q <= steer_n;
				left_ratio_q  <= left_ratio_n;
				right_ratio_q <= right_ratio_n;
				blink_count_q <= blink_n;
				led_level_q   <= led_n;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign forward     = forward_q;
	assign left_duty   = left_duty_q;
	assign right_duty  = right_duty_q;
	assign led_on      = led_on_q;
	assign auto_active = auto_active_q;

`ifndef SYNTH
	a_levels_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		speed_level_q <= LevelMax && steer_level_q <= LevelMax)
		else $error("drive level out of range");

	a_manual_led_solid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !auto_active_q |-> led_on_q)
		else $error("LED not solid in manual mode");

	a_auto_drives_forward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && auto_active_q |-> forward_q)
		else $error("reverse drive in auto mode");

	a_duty_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> left_duty_q <= FullDuty && right_duty_q <= FullDuty)
		else $error("duty above full scale");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both stages are full");
`endif

endmodule
